>>> rtl/rolling_block_checksum_defines.svh
// Assertion macros shared by the checksum block.
`ifndef ROLLING_BLOCK_CHECKSUM_DEFINES_SVH
`define ROLLING_BLOCK_CHECKSUM_DEFINES_SVH

// Same-cycle implication.
`define RBC_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define RBC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Condition that must never hold.
`define RBC_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

>>> rtl/rbc_pkg.sv
package rbc_pkg;

   localparam int DefMaxBlockShift = 12;
   localparam int DefHashShift     = 3;

   // Configuration register indexes and widths.
   localparam int CsrIndexW = 2;
   localparam int CsrDataW  = 4;
   localparam logic [CsrIndexW-1:0] CsrBlockShift = 2'd0;
   localparam logic [CsrIndexW-1:0] CsrTwoWindows = 2'd1;
   localparam logic [CsrIndexW-1:0] CsrWeakBytes  = 2'd2;

   localparam logic [3:0] ResetBlockShift = 4'd11;
   localparam logic       ResetTwoWindows = 1'b0;
   localparam logic [2:0] ResetWeakBytes  = 3'd4;

   // Weak checksum size that selects the byte mask for sum a.
   localparam logic [2:0]  WeakBytesByte = 3'd3;
   localparam logic [15:0] MaskNone      = 16'h0000;
   localparam logic [15:0] MaskByte      = 16'h00ff;
   localparam logic [15:0] MaskWord      = 16'hffff;

   localparam int KeyW = 19;

   // Result queue.
   localparam int FifoDepth = 4;
   localparam int FifoPtrW  = $clog2(FifoDepth);
   localparam int FifoCntW  = $clog2(FifoDepth + 1);

   // One byte between the memory read and the sum update.
   typedef struct packed {
      logic       valid;
      logic       restart;
      logic       use_old1;
      logic       use_old2;
      logic       ready;
      logic [7:0] data;
   } stage_type;

   typedef struct packed {
      logic [15:0]     first_sum_a;
      logic [15:0]     first_sum_b;
      logic [15:0]     second_sum_a;
      logic [15:0]     second_sum_b;
      logic [KeyW-1:0] hash_key;
      logic            window_ready;
   } result_type;

endpackage

>>> rtl/rbc_ram.sv
module rbc_ram #(
   parameter int Width = 8,
   parameter int Depth = 8192
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr_a,
   input  logic [$clog2(Depth)-1:0] rd_addr_b,
   output logic [Width-1:0]         rd_data_a,
   output logic [Width-1:0]         rd_data_b
);

   logic [Width-1:0] mem [Depth];

   // Reads return the contents from before a write in the same cycle.
   always_ff @(posedge clock) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

endmodule

>>> rtl/rbc_sums.sv
module rbc_sums #(
   parameter int ShiftW    = 4,
   parameter int HashShift = rbc_pkg::DefHashShift
) (
   input  logic                   clock,
   input  logic                   reset,
   input  rbc_pkg::stage_type     stage,
   input  logic [7:0]             old1_raw,
   input  logic [7:0]             old2_raw,
   input  logic [ShiftW-1:0]      shift,
   input  logic                   two_windows,
   input  logic [2:0]             weak_bytes,
   output logic                   res_valid,
   output rbc_pkg::result_type    res
);

   logic [15:0] fa_ff, fb_ff, sa_ff, sb_ff;
   logic [15:0] fa_in, fb_in, sa_in, sb_in;
   logic [15:0] fa_base, fb_base, sa_base, sb_base;
   logic [15:0] fa_new, fb_new, sa_new, sb_new;
   logic [15:0] old1, old2, old1_sh, old2_sh, c16, mask, x;

   always_comb begin
      old1 = stage.use_old1 ? {8'd0, old1_raw} : 16'd0;
      old2 = stage.use_old2 ? {8'd0, old2_raw} : 16'd0;
      old1_sh = 16'(32'(old1) << shift);
      old2_sh = 16'(32'(old2) << shift);
      c16 = {8'd0, stage.data};

      // A restart rolls from cleared sums.
      fa_base = stage.restart ? 16'd0 : fa_ff;
      fb_base = stage.restart ? 16'd0 : fb_ff;
      sa_base = stage.restart ? 16'd0 : sa_ff;
      sb_base = stage.restart ? 16'd0 : sb_ff;

      if (two_windows) begin
         sa_new = sa_base + c16 - old1;
         sb_new = sb_base + sa_new - old1_sh;
         fa_new = fa_base + old1 - old2;
         fb_new = fb_base + fa_new - old2_sh;
      end else begin
         fa_new = fa_base + c16 - old1;
         fb_new = fb_base + fa_new - old1_sh;
         sa_new = sa_base;
         sb_new = sb_base;
      end

      fa_in = stage.valid ? fa_new : fa_ff;
      fb_in = stage.valid ? fb_new : fb_ff;
      sa_in = stage.valid ? sa_new : sa_ff;
      sb_in = stage.valid ? sb_new : sb_ff;

      priority if (weak_bytes < rbc_pkg::WeakBytesByte) begin
         mask = rbc_pkg::MaskNone;
      end else if (weak_bytes == rbc_pkg::WeakBytesByte) begin
         mask = rbc_pkg::MaskByte;
      end else begin
         mask = rbc_pkg::MaskWord;
      end

      x = two_windows ? sb_new : (fa_new & mask);

      res_valid          = stage.valid;
      res.first_sum_a    = fa_new & mask;
      res.first_sum_b    = fb_new;
      res.second_sum_a   = two_windows ? (sa_new & mask) : 16'd0;
      res.second_sum_b   = two_windows ? sb_new : 16'd0;
      res.hash_key       = rbc_pkg::KeyW'(fb_new)
                           ^ rbc_pkg::KeyW'(32'(x) << HashShift);
      res.window_ready   = stage.ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fa_ff <= '0;
         fb_ff <= '0;
         sa_ff <= '0;
         sb_ff <= '0;
      end else begin
         fa_ff <= fa_in;
         fb_ff <= fb_in;
         sa_ff <= sa_in;
         sb_ff <= sb_in;
      end
   end

endmodule

>>> rtl/rbc_fifo.sv
`include "rolling_block_checksum_defines.svh"

module rbc_fifo (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               push,
   input  rbc_pkg::result_type                push_data,
   input  logic                               pop,
   output logic                               not_empty,
   output rbc_pkg::result_type                head,
   output logic [rbc_pkg::FifoCntW-1:0]       level
);

   rbc_pkg::result_type entries_ff [rbc_pkg::FifoDepth];
   logic [rbc_pkg::FifoPtrW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [rbc_pkg::FifoCntW-1:0] level_ff, level_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      level_in  = level_ff + rbc_pkg::FifoCntW'(push) - rbc_pkg::FifoCntW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign not_empty = level_ff != '0;
   assign head      = entries_ff[rd_ptr_ff];
   assign level     = level_ff;

   `RBC_ASSERT_NEVER(fifo_no_overflow, clock, reset,
      push && !pop && level_ff == rbc_pkg::FifoCntW'(rbc_pkg::FifoDepth),
      "result queue overflow")
   `RBC_ASSERT_NEXT(fifo_pop_drains, clock, reset, pop && !push,
      level_ff == $past(level_ff) - 1'b1, "result queue level did not drop on a pop")

endmodule

>>> rtl/rolling_block_checksum.sv
// Rolling block checksum over a sliding window of source bytes.
//
// Source bytes arrive on the req_ channel, one per transfer, with a restart
// flag in req_tuser that clears the window and the sums before that byte.
// Each accepted byte produces exactly one result transfer on the rsp_
// channel carrying both window sums, the lookup hash key and a ready flag.
// The csr_ port writes block_shift, two_windows and weak_checksum_bytes; the
// user must write it only with no bytes in flight; unchecked by the block.
//
// A byte is registered into the sum stage, its result into the result queue,
// whose level drives rsp_tvalid. One byte per cycle while req_tready is high,
// set by the sum update and the memory's two reads and one write in every cycle.
//
// Reset clears the sums, the pointers and the counters; the history memory
// is not swept. A count of bytes written since restart tells whether each
// history read refers to a byte of the current run, and older contents read
// as zero, so the block takes bytes in the first cycle after reset.
//
// When the receiver stalls, results collect in a four-entry queue; req_tready
// drops once three results are queued or in flight and rises as they drain.
`include "rolling_block_checksum_defines.svh"

module rolling_block_checksum #(
   parameter int MaxBlockShift = rbc_pkg::DefMaxBlockShift,
   parameter int HashShift     = rbc_pkg::DefHashShift
) (
   input  logic                          clock,
   input  logic                          reset,
   // Input channel.
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [7:0]                    req_tdata,  // [7:0] data_byte
   input  logic [0:0]                    req_tuser,  // [0] restart
   // Result channel.
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // [15:0] first_sum_a, [31:16] first_sum_b, [47:32] second_sum_a,
   // [63:48] second_sum_b, [82:64] hash_key, [87:83] zero
   output logic [87:0]                   rsp_tdata,
   output logic [0:0]                    rsp_tuser,  // [0] window_ready
   // Configuration port.
   input  logic                          csr_wr_en,
   input  logic [rbc_pkg::CsrIndexW-1:0] csr_index,
   input  logic [rbc_pkg::CsrDataW-1:0]  csr_wdata
);

   // History holds two of the largest blocks.
   localparam int HistDepth = 2 << MaxBlockShift;
   localparam int AddrW     = MaxBlockShift + 1;
   localparam int CountW    = MaxBlockShift + 2;
   localparam int ShiftW    = $clog2(MaxBlockShift + 1);

   logic [3:0] block_shift_ff, block_shift_in;
   logic       two_windows_ff, two_windows_in;
   logic [2:0] weak_bytes_ff, weak_bytes_in;

   logic [AddrW-1:0]  wp_ff, wp_in, wp_base, rd_addr1, rd_addr2;
   logic [CountW-1:0] written_ff, written_in, written_base;
   logic [CountW-1:0] fill_ff, fill_in, fill_base;
   logic [CountW-1:0] block_len, two_len, context_len;
   logic [ShiftW-1:0] shift_used;
   logic              req_accept, restart;

   rbc_pkg::stage_type  s1_ff, s1_in;
   rbc_pkg::result_type sum_res, head;
   logic                sum_valid, rsp_accept;
   logic [rbc_pkg::FifoCntW-1:0] fifo_level;
   logic [rbc_pkg::FifoCntW:0]   in_flight;
   logic [7:0]                   old1_raw, old2_raw;

   // Configuration registers.
   always_comb begin
      block_shift_in = block_shift_ff;
      two_windows_in = two_windows_ff;
      weak_bytes_in  = weak_bytes_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            rbc_pkg::CsrBlockShift: block_shift_in = csr_wdata[3:0];
            rbc_pkg::CsrTwoWindows: two_windows_in = csr_wdata[0];
            rbc_pkg::CsrWeakBytes:  weak_bytes_in  = csr_wdata[2:0];
            default: ;
         endcase
      end
   end

   // Window geometry. Shifts above the supported maximum are clamped.
   always_comb begin
      if (32'(block_shift_ff) > 32'(MaxBlockShift)) begin
         shift_used = ShiftW'(MaxBlockShift);
      end else begin
         shift_used = ShiftW'(block_shift_ff);
      end
      block_len   = CountW'(1) << shift_used;
      two_len     = block_len << 1;
      context_len = two_windows_ff ? two_len : block_len;
   end

   // Flow control counts the queue and the byte between memory and sums,
   // so the queue never overflows and rsp_tready never reaches req_tready.
   assign in_flight  = (rbc_pkg::FifoCntW + 1)'(fifo_level)
                       + (rbc_pkg::FifoCntW + 1)'(s1_ff.valid);
   assign req_tready = in_flight <= (rbc_pkg::FifoCntW + 1)'(rbc_pkg::FifoDepth - 2);
   assign req_accept = req_tvalid && req_tready;
   assign restart    = req_tuser[0];

   // Pointer and counters as seen by this byte, after an optional restart.
   always_comb begin
      wp_base      = restart ? '0 : wp_ff;
      written_base = restart ? '0 : written_ff;
      fill_base    = restart ? '0 : fill_ff;

      // Offsets wrap modulo the history depth; two of the largest blocks
      // land on the write address itself, which the memory reads first.
      rd_addr1 = wp_base - block_len[AddrW-1:0];
      rd_addr2 = wp_base - two_len[AddrW-1:0];

      wp_in      = req_accept ? wp_base + 1'b1 : wp_ff;
      written_in = written_ff;
      fill_in    = fill_ff;
      if (req_accept) begin
         written_in = (written_base < CountW'(HistDepth)) ? written_base + 1'b1
                                                          : written_base;
         fill_in    = (fill_base < context_len) ? fill_base + 1'b1 : context_len;
      end

      s1_in.valid    = req_accept;
      s1_in.restart  = restart;
      s1_in.use_old1 = written_base >= block_len;
      s1_in.use_old2 = written_base >= two_len;
      s1_in.ready    = fill_in >= context_len;
      s1_in.data     = req_tdata;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         block_shift_ff <= rbc_pkg::ResetBlockShift;
         two_windows_ff <= rbc_pkg::ResetTwoWindows;
         weak_bytes_ff  <= rbc_pkg::ResetWeakBytes;
         wp_ff          <= '0;
         written_ff     <= '0;
         fill_ff        <= '0;
         s1_ff          <= '0;
      end else begin
         block_shift_ff <= block_shift_in;
         two_windows_ff <= two_windows_in;
         weak_bytes_ff  <= weak_bytes_in;
         wp_ff          <= wp_in;
         written_ff     <= written_in;
         fill_ff        <= fill_in;
         s1_ff          <= s1_in;
      end
   end

   rbc_ram #(
      .Width (8),
      .Depth (HistDepth)
   ) u_history (
      .clock     (clock),
      .wr_en     (req_accept),
      .wr_addr   (wp_base),
      .wr_data   (req_tdata),
      .rd_addr_a (rd_addr1),
      .rd_addr_b (rd_addr2),
      .rd_data_a (old1_raw),
      .rd_data_b (old2_raw)
   );

   rbc_sums #(
      .ShiftW    (ShiftW),
      .HashShift (HashShift)
   ) u_sums (
      .clock       (clock),
      .reset       (reset),
      .stage       (s1_ff),
      .old1_raw    (old1_raw),
      .old2_raw    (old2_raw),
      .shift       (shift_used),
      .two_windows (two_windows_ff),
      .weak_bytes  (weak_bytes_ff),
      .res_valid   (sum_valid),
      .res         (sum_res)
   );

   assign rsp_accept = rsp_tvalid && rsp_tready;

   rbc_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (sum_valid),
      .push_data (sum_res),
      .pop       (rsp_accept),
      .not_empty (rsp_tvalid),
      .head      (head),
      .level     (fifo_level)
   );

   assign rsp_tdata = {5'd0, head.hash_key, head.second_sum_b, head.second_sum_a,
                       head.first_sum_b, head.first_sum_a};
   assign rsp_tuser = head.window_ready;

   `RBC_ASSERT_NEXT(accept_loads_stage, clock, reset, req_accept,
      s1_ff.valid, "accepted byte did not reach the sum stage")
   `RBC_ASSERT_NEXT(restart_rewinds, clock, reset, req_accept && restart,
      wp_ff == AddrW'(1) && written_ff == CountW'(1), "restart did not rewind the history")
   `RBC_ASSERT_IMPL(written_bounded, clock, reset, 1'b1,
      written_ff <= CountW'(HistDepth), "history count exceeds its depth")
   `RBC_ASSERT_IMPL(no_accept_when_busy, clock, reset, req_accept,
      fifo_level < rbc_pkg::FifoCntW'(rbc_pkg::FifoDepth), "byte accepted with a full queue")

endmodule

>>> bench/rolling_block_checksum_tb.sv
`timescale 1ns / 1ps

module rolling_block_checksum_tb;

   // Geometry of the block under test, taken from its defaults.
   localparam int MaxShift  = rbc_pkg::DefMaxBlockShift;
   localparam int HashShift = rbc_pkg::DefHashShift;
   localparam int HistDepth = 2 << MaxShift;

   // Index that decodes to no register; a write to it must change nothing.
   localparam logic [rbc_pkg::CsrIndexW-1:0] CsrUnused = 2'd3;

   // Timing of the run.
   localparam int SettleCycles  = 4;       // quiet cycles before a register write
   localparam int EndCycles     = 8;       // quiet cycles after the last result
   localparam int HoldOffCycles = 80;      // long receiver stall
   localparam int CycleLimit    = 200000;
   localparam int RandomItems   = 850;
   localparam int MaxReports    = 10;
   localparam int IdlePercent   = 36;

   typedef struct packed {
      logic [15:0]              first_sum_a;
      logic [15:0]              first_sum_b;
      logic [15:0]              second_sum_a;
      logic [15:0]              second_sum_b;
      logic [rbc_pkg::KeyW-1:0] hash_key;
      logic                     window_ready;
      logic [4:0]               pad;
   } checksum_result_type;

   typedef enum logic {RowWrite, RowByte} row_kind_type;

   // One line of the directed stimulus. Rows with typed set carry a result that
   // can be worked out by hand; the others take the predictor's answer.
   typedef struct {
      row_kind_type                    kind;
      logic [rbc_pkg::CsrIndexW-1:0]   index;
      logic [rbc_pkg::CsrDataW-1:0]    wdata;
      logic [7:0]                      data;
      logic                            restart;
      logic                            typed;
      checksum_result_type             want;
   } stim_row_type;

   logic                          clock = 1'b0;
   logic                          reset;
   logic                          req_tvalid;
   logic                          req_tready;
   logic [7:0]                    req_tdata;  // [7:0] data_byte
   logic [0:0]                    req_tuser;  // [0] restart
   logic                          rsp_tvalid;
   logic                          rsp_tready;
   // [15:0] first_sum_a, [31:16] first_sum_b, [47:32] second_sum_a,
   // [63:48] second_sum_b, [82:64] hash_key, [87:83] zero
   logic [87:0]                   rsp_tdata;
   logic [0:0]                    rsp_tuser;  // [0] window_ready
   logic                          csr_wr_en;
   logic [rbc_pkg::CsrIndexW-1:0] csr_index;
   logic [rbc_pkg::CsrDataW-1:0]  csr_wdata;

   // Results still owed by the block, oldest first.
   checksum_result_type pending_sums[$];

   int mismatch_count = 0;
   int cycle_count    = 0;

   // Set by the stimulus to ask the receiver for one long stall; cleared by the
   // receiver once it has begun the stall.
   bit hold_off_request = 1'b0;
   // While set, neither side idles.
   bit steady_stretch = 1'b0;

   // Predictor state. The first window holds the older block, the second window
   // the newer one; in one-window mode only the first window rolls.
   logic [7:0]  window_bytes [HistDepth];
   logic [15:0] older_a, older_b, newer_a, newer_b;
   int          store_ptr;
   int          bytes_seen;
   logic [3:0]  cfg_shift;
   logic        cfg_two;
   logic [2:0]  cfg_weak;

   rolling_block_checksum uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   // A restart (and reset) empties the delay line and zeroes both windows.
   function automatic void clear_windows();
      for (int i = 0; i < HistDepth; i++) begin
         window_bytes[i] = 8'h00;
      end
      older_a    = 16'h0000;
      older_b    = 16'h0000;
      newer_a    = 16'h0000;
      newer_b    = 16'h0000;
      store_ptr  = 0;
      bytes_seen = 0;
   endfunction

   // Rolls one window by a byte: the byte sum gains the entering byte and loses
   // the leaving one, then the weighted sum gains the new byte sum and loses the
   // leaving byte scaled by the block size. Both wrap at 16 bits.
   // Returns {b, a}.
   function automatic logic [31:0] roll_pair(input logic [15:0] a, input logic [15:0] b,
                                             input logic [7:0] leaving,
                                             input logic [7:0] entering, input int sh);
      logic [31:0] wide;
      logic [15:0] na;
      logic [15:0] nb;
      wide = {16'h0000, a} + {24'h000000, entering} - {24'h000000, leaving};
      na   = wide[15:0];
      wide = {16'h0000, b} + {16'h0000, na} - ({24'h000000, leaving} << sh);
      nb   = wide[15:0];
      return {nb, na};
   endfunction

   function automatic void apply_register(input logic [rbc_pkg::CsrIndexW-1:0] idx,
                                          input logic [rbc_pkg::CsrDataW-1:0] val);
      case (idx)
         rbc_pkg::CsrBlockShift: begin
            cfg_shift = val;
         end
         rbc_pkg::CsrTwoWindows: begin
            cfg_two = val[0];
         end
         rbc_pkg::CsrWeakBytes: begin
            cfg_weak = val[2:0];
         end
         default: begin
         end
      endcase
   endfunction

   // Works out the result that one accepted byte produces and advances the
   // predictor state accordingly.
   function automatic void predict_checksums(input logic [7:0] d, input logic rs,
                                             output checksum_result_type r);
      int          sh;
      int          span;
      int          ctx;
      logic [15:0] mask;
      logic [15:0] keyed;
      logic [7:0]  leave_new;
      logic [7:0]  leave_old;
      logic [31:0] pair;
      logic [31:0] key_wide;

      // Oversized shifts are clipped to the largest block size; small ones are
      // taken as they are.
      sh   = (cfg_shift > MaxShift) ? MaxShift : int'(cfg_shift);
      span = 1 << sh;
      ctx  = cfg_two ? 2 * span : span;
      if (cfg_weak < rbc_pkg::WeakBytesByte) begin
         mask = rbc_pkg::MaskNone;
      end else if (cfg_weak == rbc_pkg::WeakBytesByte) begin
         mask = rbc_pkg::MaskByte;
      end else begin
         mask = rbc_pkg::MaskWord;
      end

      if (rs) begin
         clear_windows();
      end

      // The byte one block back leaves the newer window (and, in two-window
      // mode, enters the older one); the byte two blocks back leaves the older.
      leave_new = window_bytes[(store_ptr - span) & (HistDepth - 1)];
      leave_old = window_bytes[(store_ptr - 2 * span) & (HistDepth - 1)];

      if (cfg_two) begin
         pair    = roll_pair(newer_a, newer_b, leave_new, d, sh);
         newer_a = pair[15:0];
         newer_b = pair[31:16];
         pair    = roll_pair(older_a, older_b, leave_old, leave_new, sh);
         older_a = pair[15:0];
         older_b = pair[31:16];
      end else begin
         pair    = roll_pair(older_a, older_b, leave_new, d, sh);
         older_a = pair[15:0];
         older_b = pair[31:16];
      end

      window_bytes[store_ptr] = d;
      store_ptr = (store_ptr + 1) & (HistDepth - 1);

      // The fill count saturates at the context length, and is pulled down to
      // it when the context has just shrunk.
      bytes_seen = (bytes_seen < ctx) ? bytes_seen + 1 : ctx;

      keyed    = cfg_two ? newer_b : (older_a & mask);
      key_wide = {16'h0000, older_b} ^ ({16'h0000, keyed} << HashShift);

      r.first_sum_a  = older_a & mask;
      r.first_sum_b  = older_b;
      r.second_sum_a = cfg_two ? (newer_a & mask) : 16'h0000;
      r.second_sum_b = cfg_two ? newer_b : 16'h0000;
      r.hash_key     = key_wide[rbc_pkg::KeyW-1:0];
      r.window_ready = (bytes_seen >= ctx);
      r.pad          = '0;
   endfunction

   // ---------------------------------------------------------------------
   // Directed rows
   // ---------------------------------------------------------------------

   function automatic stim_row_type write_row(input logic [rbc_pkg::CsrIndexW-1:0] idx,
                                              input logic [rbc_pkg::CsrDataW-1:0] val);
      stim_row_type row;
      row         = '{kind: RowWrite, default: '0};
      row.index   = idx;
      row.wdata   = val;
      return row;
   endfunction

   function automatic stim_row_type byte_row(input logic [7:0] d, input logic rs);
      stim_row_type row;
      row         = '{kind: RowByte, default: '0};
      row.data    = d;
      row.restart = rs;
      return row;
   endfunction

   function automatic stim_row_type checked_row(input logic [7:0] d, input logic rs,
                                                input logic [15:0] a, input logic [15:0] b,
                                                input logic [15:0] a2, input logic [15:0] b2,
                                                input logic [rbc_pkg::KeyW-1:0] key,
                                                input logic rdy);
      stim_row_type row;
      row                   = byte_row(d, rs);
      row.typed             = 1'b1;
      row.want.first_sum_a  = a;
      row.want.first_sum_b  = b;
      row.want.second_sum_a = a2;
      row.want.second_sum_b = b2;
      row.want.hash_key     = key;
      row.want.window_ready = rdy;
      row.want.pad          = '0;
      return row;
   endfunction

   // ---------------------------------------------------------------------
   // Driving the input channel and the register port
   // ---------------------------------------------------------------------

   // Waits until every owed result has come back, then lets the clock run on so
   // that nothing is still moving inside the block.
   task automatic settle_idle();
      req_tvalid <= 1'b0;
      while (pending_sums.size() != 0) begin
         @(posedge clock);
      end
      repeat (SettleCycles) @(posedge clock);
   endtask

   // Back-to-back register writes keep the write enable high; the first write
   // of a group waits for the block to go quiet.
   task automatic write_register(input logic [rbc_pkg::CsrIndexW-1:0] idx,
                                 input logic [rbc_pkg::CsrDataW-1:0] val);
      if (!csr_wr_en) begin
         settle_idle();
      end
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      apply_register(idx, val);
   endtask

   // Offers one byte and holds it until the transfer happens. The valid stays
   // high afterwards so that the next byte can follow without a gap.
   task automatic send_byte(input logic [7:0] d, input logic rs, input logic typed,
                            input checksum_result_type want);
      checksum_result_type predicted;
      if (csr_wr_en) begin
         csr_wr_en <= 1'b0;
         @(posedge clock);
      end
      while (!steady_stretch && ($urandom_range(99) < IdlePercent)) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      req_tuser  <= rs;
      do begin
         @(posedge clock);
      end while (!req_tready);
      predict_checksums(d, rs, predicted);
      pending_sums.push_back(typed ? want : predicted);
   endtask

   // ---------------------------------------------------------------------
   // Result channel: random back-pressure and checking
   // ---------------------------------------------------------------------

   function automatic string describe(input checksum_result_type r);
      return $sformatf("a1=%h b1=%h a2=%h b2=%h key=%h ready=%b pad=%h",
                       r.first_sum_a, r.first_sum_b, r.second_sum_a, r.second_sum_b,
                       r.hash_key, r.window_ready, r.pad);
   endfunction

   task automatic check_result();
      checksum_result_type got;
      checksum_result_type want;
      got.first_sum_a  = rsp_tdata[15:0];
      got.first_sum_b  = rsp_tdata[31:16];
      got.second_sum_a = rsp_tdata[47:32];
      got.second_sum_b = rsp_tdata[63:48];
      got.hash_key     = rsp_tdata[82:64];
      got.pad          = rsp_tdata[87:83];
      got.window_ready = rsp_tuser[0];
      if (pending_sums.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= MaxReports) begin
            $display("[%0t] result transfer with nothing owed: %s", $realtime, describe(got));
         end
      end else begin
         want = pending_sums.pop_front();
         if ((got.first_sum_a  !== want.first_sum_a)  ||
             (got.first_sum_b  !== want.first_sum_b)  ||
             (got.second_sum_a !== want.second_sum_a) ||
             (got.second_sum_b !== want.second_sum_b) ||
             (got.hash_key     !== want.hash_key)     ||
             (got.window_ready !== want.window_ready) ||
             (got.pad          !== want.pad)) begin
            mismatch_count++;
            if (mismatch_count <= MaxReports) begin
               $display("[%0t] checksum mismatch", $realtime);
               $display("   expected %s", describe(want));
               $display("   actual   %s", describe(got));
            end
         end
      end
   endtask

   // The receiver decides its ready for the next cycle at every edge. A long
   // stall, when asked for, is counted out here while the sender keeps
   // offering bytes, so the result queue fills and the input backs up.
   initial begin
      int   hold_left;
      logic next_ready;
      hold_left = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            check_result();
         end
         if (hold_left > 0) begin
            hold_left--;
            next_ready = 1'b0;
         end else if (hold_off_request) begin
            hold_off_request = 1'b0;
            hold_left = HoldOffCycles - 1;
            next_ready = 1'b0;
         end else begin
            next_ready = steady_stretch || ($urandom_range(99) >= IdlePercent);
         end
         rsp_tready <= next_ready;
      end
   end

   // Watchdog: a run that has not ended by the limit counts as failed.
   initial begin
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Simulation FAILED");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------

   initial begin
      stim_row_type        plan[$];
      checksum_result_type blank;
      int                  random_items;
      int                  phase;
      int                  run_len;
      int                  pick;
      bit                  fresh;
      logic [3:0]          shift_val;
      logic [3:0]          two_val;
      logic [3:0]          weak_val;
      logic [7:0]          d;
      logic                rs;

      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= 8'h00;
      req_tuser  <= 1'b0;
      csr_wr_en  <= 1'b0;
      csr_index  <= rbc_pkg::CsrBlockShift;
      csr_wdata  <= '0;
      blank      = '0;

      clear_windows();
      cfg_shift = rbc_pkg::ResetBlockShift;
      cfg_two   = rbc_pkg::ResetTwoWindows;
      cfg_weak  = rbc_pkg::ResetWeakBytes;

      // Settings straight out of reset: 2 KiB block, one window, full mask.
      plan.push_back(checked_row(8'hFF, 1'b0, 16'h00FF, 16'h00FF, 16'h0000, 16'h0000,
                                 19'h00707, 1'b0));
      // A restart on a zero byte leaves every sum at zero.
      plan.push_back(checked_row(8'h00, 1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                                 19'h00000, 1'b0));
      // A shift below the nominal range is used as it is: a one-byte block,
      // which is ready after the first byte.
      plan.push_back(write_row(rbc_pkg::CsrBlockShift, 4'd0));
      plan.push_back(checked_row(8'hFF, 1'b1, 16'h00FF, 16'h00FF, 16'h0000, 16'h0000,
                                 19'h00707, 1'b1));
      plan.push_back(checked_row(8'h01, 1'b0, 16'h0001, 16'h0001, 16'h0000, 16'h0000,
                                 19'h00009, 1'b1));
      // Weak checksum under three bytes masks the byte sum away entirely.
      plan.push_back(write_row(rbc_pkg::CsrWeakBytes, 4'd0));
      plan.push_back(checked_row(8'h80, 1'b0, 16'h0000, 16'h0080, 16'h0000, 16'h0000,
                                 19'h00080, 1'b1));
      // Three bytes keeps the low byte of sum a only; a two-byte block of 0xff.
      plan.push_back(write_row(rbc_pkg::CsrWeakBytes, {1'b0, rbc_pkg::WeakBytesByte}));
      plan.push_back(write_row(rbc_pkg::CsrBlockShift, 4'd1));
      plan.push_back(checked_row(8'hFF, 1'b1, 16'h00FF, 16'h00FF, 16'h0000, 16'h0000,
                                 19'h00707, 1'b0));
      plan.push_back(checked_row(8'hFF, 1'b0, 16'h00FE, 16'h02FD, 16'h0000, 16'h0000,
                                 19'h0050D, 1'b1));
      // Two one-byte windows: the byte leaving the newer window turns up in the
      // older one a step later.
      plan.push_back(write_row(rbc_pkg::CsrWeakBytes, 4'd7));
      plan.push_back(write_row(rbc_pkg::CsrTwoWindows, 4'd1));
      plan.push_back(write_row(rbc_pkg::CsrBlockShift, 4'd0));
      plan.push_back(checked_row(8'hFF, 1'b1, 16'h0000, 16'h0000, 16'h00FF, 16'h00FF,
                                 19'h007F8, 1'b0));
      plan.push_back(checked_row(8'h10, 1'b0, 16'h00FF, 16'h00FF, 16'h0010, 16'h0010,
                                 19'h0007F, 1'b1));
      plan.push_back(checked_row(8'h00, 1'b0, 16'h0010, 16'h0010, 16'h0000, 16'h0000,
                                 19'h00010, 1'b1));
      // Dropping to one window with a full context shrinks the fill count.
      plan.push_back(write_row(rbc_pkg::CsrTwoWindows, 4'd0));
      plan.push_back(byte_row(8'h7F, 1'b0));
      // An oversized shift is clipped to the largest block; the spare index
      // must be ignored.
      plan.push_back(write_row(rbc_pkg::CsrBlockShift, 4'd15));
      plan.push_back(write_row(rbc_pkg::CsrTwoWindows, 4'd1));
      plan.push_back(write_row(CsrUnused, 4'hF));
      plan.push_back(byte_row(8'h00, 1'b1));
      plan.push_back(byte_row(8'hFF, 1'b0));
      plan.push_back(byte_row(8'hFF, 1'b0));
      plan.push_back(byte_row(8'h01, 1'b0));
      // Changing settings mid-stream without a restart: the sums roll on.
      plan.push_back(write_row(rbc_pkg::CsrBlockShift, 4'd4));
      plan.push_back(write_row(rbc_pkg::CsrWeakBytes, 4'd1));
      plan.push_back(byte_row(8'hFF, 1'b0));

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[n]) begin
         if (plan[n].kind == RowWrite) begin
            write_register(plan[n].index, plan[n].wdata);
         end else begin
            send_byte(plan[n].data, plan[n].restart, plan[n].typed, plan[n].want);
         end
      end

      // Random part, in phases. Each phase picks a setting while the block is
      // quiet and then streams a run of bytes. Most phases open with a restart;
      // the rest carry the sums over into the new setting. Small blocks
      // dominate so that windows fill and the ready flag is reached often.
      random_items = 0;
      phase        = 0;
      while (random_items < RandomItems) begin
         if (phase == 0) begin
            shift_val = 4'd4;
            two_val   = 4'd0;
            weak_val  = 4'd4;
         end else if (phase == 1) begin
            shift_val = 4'd12;
            two_val   = 4'd1;
            weak_val  = 4'd1;
         end else begin
            pick = $urandom_range(99);
            if (pick < 55) begin
               shift_val = 4'($urandom_range(5));
            end else if (pick < 85) begin
               shift_val = 4'($urandom_range(8, 6));
            end else begin
               shift_val = 4'($urandom_range(15, 9));
            end
            // Upper bits of the write data are don't-care for the narrow
            // registers, so they are filled at random.
            two_val  = 4'($urandom_range(15));
            weak_val = 4'($urandom_range(15));
         end
         write_register(rbc_pkg::CsrBlockShift, shift_val);
         write_register(rbc_pkg::CsrTwoWindows, two_val);
         write_register(rbc_pkg::CsrWeakBytes, weak_val);

         run_len = $urandom_range(130, 40);
         fresh   = (phase < 2) || ($urandom_range(3) != 0);
         for (int k = 0; (k < run_len) && (random_items < RandomItems); k++) begin
            pick = $urandom_range(9);
            if (pick == 0) begin
               d = 8'h00;
            end else if (pick == 1) begin
               d = 8'hFF;
            end else begin
               d = 8'($urandom_range(255));
            end
            rs = ((k == 0) && fresh) || ($urandom_range(49) == 0);
            steady_stretch = (random_items >= 600) && (random_items < 720);
            if ((random_items == 150) || (random_items == 480)) begin
               hold_off_request = 1'b1;
            end
            send_byte(d, rs, 1'b0, blank);
            random_items++;
         end
         phase++;
      end

      steady_stretch = 1'b0;
      req_tvalid <= 1'b0;
      while (pending_sums.size() != 0) begin
         @(posedge clock);
      end
      repeat (EndCycles) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
